// ===== src/nearest_segment_projection_core_assert.svh =====
// Assertion macros for the nearest segment projection core.
// Used by the port-level checker; no other dependencies.
`ifndef NEAREST_SEGMENT_PROJECTION_CORE_ASSERT_SVH
`define NEAREST_SEGMENT_PROJECTION_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define NSP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("label failed");
// next-cycle implication
`define NSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("label failed");
`endif

// ===== src/nsp_pkg.sv =====
// Package for the nearest segment projection core: widths, defaults, FSM type.
// No dependencies.
`timescale 1ns / 1ps
package nsp_pkg;
	localparam int DEF_GRID_WIDTH   = 16;
	localparam int DEF_GRID_HEIGHT  = 16;
	localparam int DEF_COORD_BITS   = 12;
	localparam int DEF_T_FRAC_BITS  = 16;
	localparam int DEF_MAX_SEGMENTS = 64;
	localparam int CELL_BITS  = 4;
	localparam int SEG_BITS   = 6;
	localparam int DIST_BITS  = 36;
	localparam int ORDER_BITS = 23;
	localparam logic [DIST_BITS-1:0] DIST_INF = '1;
	localparam logic [DIST_BITS-1:0] DIST_MAX = DIST_INF - 36'd1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_SQ, ST_DIV, ST_RD, ST_WB, ST_OUT, ST_CLR
	} nsp_state_t;

	// request to the divider
	typedef struct packed {
		logic start;
		logic tq_mode;
	} nsp_div_ctl_t;
endpackage

// ===== src/nsp_divider.sv =====
// Restoring divider: one quotient bit per cycle, floor(num / den).
// Depends on nsp_pkg.
`timescale 1ns / 1ps
module nsp_divider import nsp_pkg::*; #(
	parameter int NUM_BITS = 72,
	parameter int DEN_BITS = 40,
	parameter int Q_BITS   = 37
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                done,
	output logic [Q_BITS-1:0]   quo,
	output logic                ovf
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);
	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS:0]   rem_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic [DEN_BITS:0]   shifted;
	logic                ge;

	assign shifted = {rem_q[DEN_BITS-1:0], num_q[NUM_BITS-1]};
	assign ge      = shifted >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			quo   <= '0;
			ovf   <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_BITS-2:0], 1'b0};
			rem_q <= ge ? shifted - {1'b0, den} : shifted;
			quo   <= {quo[Q_BITS-2:0], ge};
			if (quo[Q_BITS-1])
				ovf <= 1'b1;
		end
	end
endmodule

// ===== src/nsp_cell_store.sv =====
// Per-cell best store: one synchronous RAM with a registered read.
// Depends on nsp_pkg.
`timescale 1ns / 1ps
module nsp_cell_store import nsp_pkg::*; #(
	parameter int CELLS = 256,
	parameter int W     = DIST_BITS + ORDER_BITS + 1
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(CELLS)-1:0] rd_addr,
	output logic [W-1:0]             rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(CELLS)-1:0] wr_addr,
	input  logic [W-1:0]             wr_data
);
	logic [W-1:0] mem [CELLS];
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end
endmodule

// ===== src/nearest_segment_projection_core.sv =====
// Nearest segment projection core: one cell/segment beat in, one result beat out.
// Steps: products, square, two serial divides (distance, then t) of 4*COORD_BITS+16
// numerator bits at one bit a cycle, read, write back. Out-of-range pairs skip both divides.
// One item at a time; in_ready is back the cycle after the result beat is taken.
// Reset: a clearing pass writes infinity to every cell, in_ready stays low.
`timescale 1ns / 1ps
module nearest_segment_projection_core import nsp_pkg::*; #(
	parameter int COORD_BITS   = DEF_COORD_BITS,
	parameter int T_FRAC_BITS  = DEF_T_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [CELL_BITS-1:0]         cell_x,
	input  logic [CELL_BITS-1:0]         cell_y,
	input  logic signed [COORD_BITS-1:0] seg_start_x,
	input  logic signed [COORD_BITS-1:0] seg_start_y,
	input  logic signed [COORD_BITS-1:0] seg_end_x,
	input  logic signed [COORD_BITS-1:0] seg_end_y,
	input  logic [SEG_BITS-1:0]          segment_number,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         in_range,
	output logic                         updated,
	output logic [DIST_BITS-1:0]         best_sq_distance,
	output logic [ORDER_BITS-1:0]        best_order,
	output logic                         best_side,
	output logic                         best_valid
);
	// grid and segment count follow the fixed port widths
	localparam int GRID_WIDTH   = DEF_GRID_WIDTH;
	localparam int GRID_HEIGHT  = DEF_GRID_HEIGHT;
	localparam int MAX_SEGMENTS = DEF_MAX_SEGMENTS;
	localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW     = $clog2(CELLS);
	localparam int XW     = $clog2(GRID_WIDTH);
	localparam int YW     = $clog2(GRID_HEIGHT);
	localparam int SW     = $clog2(MAX_SEGMENTS);
	localparam int DW     = COORD_BITS + 2;      // difference width, signed
	localparam int LW     = 2 * DW;              // len2 / dot / cross width
	localparam int NUMW   = 2 * LW + 8;          // cross^2 * 256
	localparam int QW     = DIST_BITS + 1;
	localparam int MW     = DIST_BITS + ORDER_BITS + 1;

	nsp_state_t state_q, state_d;

	// captured item
	logic [AW-1:0]          idx_q;
	logic [SW-1:0]          seg_q;
	logic signed [DW-1:0]   dx_q, dy_q, rx_q, ry_q;
	// products, registered
	logic signed [LW-1:0]   len2_q, dot_q, cross_q;
	logic [NUMW-1:0]        sq_q;
	logic                   ok_q, side_q, tq_phase_q, started_q;
	logic [DIST_BITS-1:0]   dist_q;
	logic [T_FRAC_BITS:0]   tq_q;
	logic [AW-1:0]          clr_q;
	logic [MW-1:0]          rd_data, wr_data;
	logic                   upd_q;
	logic                   rd_en, wr_en;
	logic [AW-1:0]          wr_addr;
	nsp_div_ctl_t           div_ctl;

	logic [XW-1:0] cxw;
	logic [YW-1:0] cyw;
	assign cxw = XW'(cell_x % GRID_WIDTH);
	assign cyw = YW'(cell_y % GRID_HEIGHT);

	// divider, shared between distance and t
	logic [NUMW-1:0] div_num;
	logic [QW-1:0]   div_quo;
	logic            div_done, div_ovf;
	assign div_num = div_ctl.tq_mode ?
		NUMW'({dot_q[LW-1:0], {T_FRAC_BITS{1'b0}}}) : sq_q;

	nsp_divider #(.NUM_BITS(NUMW), .DEN_BITS(LW), .Q_BITS(QW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_ctl.start), .num(div_num),
		.den(len2_q[LW-1:0]), .done(div_done), .quo(div_quo), .ovf(div_ovf)
	);

	nsp_cell_store #(.CELLS(CELLS), .W(MW)) u_store (
		.clk(clk), .rd_en(rd_en), .rd_addr(idx_q), .rd_data(rd_data),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
	);

	logic [DIST_BITS-1:0]  st_dist;
	assign st_dist = rd_data[MW-1 -: DIST_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR)
				clr_q <= clr_q + AW'(1);
		end
	end

	// next state and handshake
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		rd_en     = 1'b0;
		div_ctl   = '{start: 1'b0, tq_mode: tq_phase_q};
		case (state_q)
			ST_CLR: if (clr_q == AW'(CELLS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_MUL;
			end
			// products registered at the end of this cycle
			ST_MUL: state_d = ST_SQ;
			// range check, side and square registered
			ST_SQ: state_d = ST_DIV;
			ST_DIV: begin
				if (!ok_q) begin
					rd_en   = 1'b1;
					state_d = ST_RD;
				end else if (!started_q) begin
					div_ctl = '{start: 1'b1, tq_mode: 1'b0};
				end else if (div_done) begin
					if (tq_phase_q) begin
						rd_en   = 1'b1;
						state_d = ST_RD;
					end else begin
						div_ctl = '{start: 1'b1, tq_mode: 1'b1};
					end
				end
			end
			ST_RD: state_d = ST_WB;
			ST_WB: state_d = ST_OUT;
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			idx_q <= AW'({cyw, cxw});
			seg_q <= SW'(segment_number % MAX_SEGMENTS);
			dx_q  <= DW'(seg_end_x) - DW'(seg_start_x);
			dy_q  <= DW'(seg_end_y) - DW'(seg_start_y);
			rx_q  <= DW'({1'b0, cxw}) - DW'(seg_start_x);
			ry_q  <= DW'({1'b0, cyw}) - DW'(seg_start_y);
			tq_phase_q <= 1'b0;
			started_q  <= 1'b0;
		end
		if (state_q == ST_MUL) begin
			len2_q  <= LW'(dx_q * dx_q) + LW'(dy_q * dy_q);
			dot_q   <= LW'(rx_q * dx_q) + LW'(ry_q * dy_q);
			cross_q <= LW'(dx_q * ry_q) - LW'(dy_q * rx_q);
		end
		if (state_q == ST_SQ) begin
			ok_q   <= (len2_q != '0) && !dot_q[LW-1] && (dot_q <= len2_q);
			side_q <= cross_q[LW-1];
			// cross^2 with 8 fraction bits; the square of a signed value is never negative
			sq_q   <= {(2*LW)'(cross_q) * (2*LW)'(cross_q), 8'd0};
		end
		if (div_ctl.start)
			started_q <= 1'b1;
		if (div_ctl.start && div_ctl.tq_mode)
			tq_phase_q <= 1'b1;
		if (div_done && !tq_phase_q)
			dist_q <= (div_ovf || div_quo[QW-1] || div_quo[DIST_BITS-1:0] > DIST_MAX)
				? DIST_MAX : div_quo[DIST_BITS-1:0];
		if (div_done && tq_phase_q)
			tq_q <= div_quo[T_FRAC_BITS:0];
		if (state_q == ST_WB)
			upd_q <= ok_q && (dist_q < st_dist);
	end

	// write back the new best, or clear
	logic                  upd_now;
	logic [ORDER_BITS-1:0] ord;
	assign upd_now = (state_q == ST_WB) && ok_q && (dist_q < st_dist);
	assign ord = ORDER_BITS'(({{(ORDER_BITS){1'b0}}, seg_q} << T_FRAC_BITS)
		+ ORDER_BITS'(tq_q));
	assign wr_en   = (state_q == ST_CLR) || upd_now;
	assign wr_addr = (state_q == ST_CLR) ? clr_q : idx_q;
	assign wr_data = (state_q == ST_CLR) ? {DIST_INF, {(ORDER_BITS+1){1'b0}}}
		: {dist_q, ord, side_q};

	// result fields
	logic [MW-1:0] res_q;
	always_ff @(posedge clk)
		if (state_q == ST_WB) res_q <= upd_now ? wr_data : rd_data;
	assign in_range         = ok_q;
	assign updated          = upd_q;
	assign best_sq_distance = res_q[MW-1 -: DIST_BITS];
	assign best_order       = res_q[ORDER_BITS:1];
	assign best_side        = res_q[0];
	assign best_valid       = res_q[MW-1 -: DIST_BITS] != DIST_INF;
endmodule

// ===== src/nsp_checker.sv =====
// Port-level checker for the nearest segment projection core, bound to the top.
// Depends on nearest_segment_projection_core_assert.svh.
`timescale 1ns / 1ps
`include "nearest_segment_projection_core_assert.svh"
module nsp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic in_range,
	input logic updated,
	input logic best_valid
);
	// one item in flight: no new beat while a result is pending
	`NSP_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
	// an update implies the projection was in range and the cell is now set
	`NSP_ASSERT_IMP(a_upd_range, out_valid && updated, in_range && best_valid)
	// accepted input never gives a result in the next cycle
	`NSP_ASSERT_NEXT(a_lat, in_valid && in_ready, !out_valid)
	// result beat held until taken
	`NSP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
endmodule

bind nearest_segment_projection_core nsp_checker u_nsp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .in_range(in_range),
	.updated(updated), .best_valid(best_valid)
);

// ===== tb/sv/tb_nearest_segment_projection_core.sv =====
// Testbench for the nearest segment projection core: directed and random cell/segment beats,
// checked against an in-bench predictor of the per-cell best store. Depends on nsp_pkg and the core.
`timescale 1ns / 1ps
module tb_nearest_segment_projection_core;
	import nsp_pkg::*;

	localparam int GW = DEF_GRID_WIDTH;
	localparam int GH = DEF_GRID_HEIGHT;
	localparam int TFB = DEF_T_FRAC_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CELL_BITS-1:0] cell_x = '0, cell_y = '0;
	logic signed [11:0] seg_start_x = '0, seg_start_y = '0, seg_end_x = '0, seg_end_y = '0;
	logic [SEG_BITS-1:0] segment_number = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic in_range, updated, best_side, best_valid;
	logic [DIST_BITS-1:0] best_sq_distance;
	logic [ORDER_BITS-1:0] best_order;

	nearest_segment_projection_core dut (.*);

	typedef struct packed {
		logic in_range;
		logic updated;
		logic [DIST_BITS-1:0] sq_dist;
		logic [ORDER_BITS-1:0] order;
		logic side;
		logic valid;
	} proj_result_t;

	// predictor's copy of the per-cell store
	logic [DIST_BITS-1:0] pred_dist [GW*GH];
	logic [ORDER_BITS-1:0] pred_order [GW*GH];
	logic pred_side [GW*GH];
	proj_result_t expected_q [$];
	int errors = 0;
	bit no_idle = 1'b0;      // stretch with no idling on either side
	int hold_cycles = 0;     // long receiver hold-off, counted down below

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb_nearest_segment_projection_core: errors");
		$finish;
	end

	// squared distance: floor(c^2*256/len2), saturated just below infinity
	function automatic proj_result_t project_cell(logic [3:0] px, logic [3:0] py,
			logic signed [11:0] sx, logic signed [11:0] sy, logic signed [11:0] ex,
			logic signed [11:0] ey, logic [5:0] seg);
		proj_result_t r;
		longint dx, dy, rx, ry, len2, dotp, crs;
		logic [127:0] num, q;
		logic [63:0] tq;
		int idx;
		dx = longint'(ex) - longint'(sx);
		dy = longint'(ey) - longint'(sy);
		rx = longint'(px) - longint'(sx);
		ry = longint'(py) - longint'(sy);
		len2 = dx*dx + dy*dy;
		dotp = rx*dx + ry*dy;
		idx = int'(py)*GW + int'(px);
		r.in_range = (len2 != 0) && (dotp >= 0) && (dotp <= len2);
		r.updated = 1'b0;
		if (r.in_range) begin
			crs = dx*ry - dy*rx;
			if (crs < 0) crs = -crs;
			num = 128'(crs) * 128'(crs) * 128'd256;
			q = num / 128'(len2);
			if (q > 128'(DIST_MAX)) q = 128'(DIST_MAX);
			if (q[DIST_BITS-1:0] < pred_dist[idx]) begin
				tq = (64'(dotp) << TFB) / 64'(len2);
				pred_dist[idx] = q[DIST_BITS-1:0];
				pred_order[idx] = ORDER_BITS'((64'(seg) << TFB) + tq);
				pred_side[idx] = (dx*ry - dy*rx) < 0;
				r.updated = 1'b1;
			end
		end
		r.sq_dist = pred_dist[idx];
		r.order = pred_order[idx];
		r.side = pred_side[idx];
		r.valid = pred_dist[idx] != DIST_INF;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	// valid stays up after acceptance; the next call or wait_drained drops it
	task automatic send_beat(logic [3:0] px, logic [3:0] py, logic signed [11:0] sx,
			logic signed [11:0] sy, logic signed [11:0] ex, logic signed [11:0] ey,
			logic [5:0] seg);
		while (!no_idle && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		cell_x <= px; cell_y <= py;
		seg_start_x <= sx; seg_start_y <= sy; seg_end_x <= ex; seg_end_y <= ey;
		segment_number <= seg;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q = {expected_q, project_cell(px, py, sx, sy, ex, ey, seg)};
	endtask

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= no_idle || ($urandom_range(99) >= 17);
	end

	// result checker: compare each accepted beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected beat", longint'(0), longint'(0));
			end else begin
				proj_result_t e;
				e = expected_q.pop_front();
				if (in_range !== e.in_range)
					report_mismatch("in_range", longint'(in_range), longint'(e.in_range));
				if (updated !== e.updated)
					report_mismatch("updated", longint'(updated), longint'(e.updated));
				if (best_sq_distance !== e.sq_dist)
					report_mismatch("best_sq_distance", longint'(best_sq_distance),
						longint'(e.sq_dist));
				if (best_order !== e.order)
					report_mismatch("best_order", longint'(best_order), longint'(e.order));
				if (best_side !== e.side)
					report_mismatch("best_side", longint'(best_side), longint'(e.side));
				if (best_valid !== e.valid)
					report_mismatch("best_valid", longint'(best_valid), longint'(e.valid));
			end
		end
	end

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// extremes, zero length, t ends, equal distance, both sides
	task automatic test_directed();
		send_beat(4'd0, 4'd0, 12'sd5, 12'sd5, 12'sd5, 12'sd5, 6'd1);          // zero length
		send_beat(4'd0, 4'd0, 12'sd0, 12'sd0, 12'sd10, 12'sd0, 6'd0);         // on segment, t=0
		send_beat(4'd0, 4'd0, 12'sd0, 12'sd0, 12'sd10, 12'sd0, 6'd3);         // equal: no update
		send_beat(4'd5, 4'd3, 12'sd0, 12'sd0, 12'sd5, 12'sd0, 6'd63);         // t=1, max seg
		send_beat(4'd5, 4'd3, 12'sd0, 12'sd0, 12'sd4, 12'sd0, 6'd2);          // t>1
		send_beat(4'd5, 4'd3, 12'sd6, 12'sd0, 12'sd9, 12'sd0, 6'd2);          // t<0
		send_beat(4'd15, 4'd15, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 6'd7);
		send_beat(4'd15, 4'd0, -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048, 6'd9);
		send_beat(4'd8, 4'd8, -12'sd2048, 12'sd8, 12'sd2047, 12'sd8, 6'd1);
		send_beat(4'd8, 4'd8, 12'sd8, -12'sd2048, 12'sd8, 12'sd2047, 6'd2);
		send_beat(4'd7, 4'd0, -12'sd2048, 12'sd2047, -12'sd2047, 12'sd2047, 6'd4); // far
		send_beat(4'd2, 4'd9, 12'sd0, 12'sd0, 12'sd0, 12'sd20, 6'd5);         // side one way
		send_beat(4'd2, 4'd9, 12'sd4, 12'sd20, 12'sd4, 12'sd0, 6'd6);         // same side, equal: no update
		send_beat(4'd2, 4'd9, 12'sd3, 12'sd0, 12'sd3, 12'sd20, 6'd10);        // closer
		send_beat(4'd15, 4'd15, 12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048, 6'd0);
		wait_drained();
	endtask

	task automatic send_random(bit near);
		logic [3:0] px, py;
		logic signed [11:0] sx, sy, ex, ey;
		px = 4'($urandom); py = 4'($urandom);
		if (near) begin
			sx = $signed(12'($urandom_range(60))) - 12'sd22;
			sy = $signed(12'($urandom_range(60))) - 12'sd22;
			ex = $signed(12'($urandom_range(60))) - 12'sd22;
			ey = $signed(12'($urandom_range(60))) - 12'sd22;
		end else begin
			sx = 12'($urandom); sy = 12'($urandom); ex = 12'($urandom); ey = 12'($urandom);
		end
		send_beat(px, py, sx, sy, ex, ey, 6'($urandom));
	endtask

	task automatic test_random();
		for (int i = 0; i < 800; i++) begin
			send_random($urandom_range(99) < 75);
			if (i == 300) wait_drained();     // sender pauses until all results are in
		end
	endtask

	task automatic test_no_idle();
		no_idle = 1'b1;
		for (int i = 0; i < 120; i++) send_random(1'b1);
		no_idle = 1'b0;
	endtask

	// long receiver hold-off while items keep coming: input must stall
	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 100; i++) send_random(1'($urandom_range(1)));
	endtask

	initial begin
		for (int i = 0; i < GW*GH; i++) begin
			pred_dist[i] = DIST_INF; pred_order[i] = '0; pred_side[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		test_no_idle();
		test_backpressure();
		wait_drained();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("tb_nearest_segment_projection_core: clean");
		else
			$display("tb_nearest_segment_projection_core: errors");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/nsp_pkg.sv
src/nsp_divider.sv
src/nsp_cell_store.sv
src/nearest_segment_projection_core.sv
src/nsp_checker.sv
tb/sv/tb_nearest_segment_projection_core.sv
